@@ sv/tscw_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the text screen cell writer
package tscw_pkg;

    // field widths of the command and response transactions
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int KIND_W      = 3;
    localparam int ADDR_FULL_W = ROW_W + COL_W;

    // defaults for the screen geometry and the command queue
    localparam int ROWS_DEFAULT    = 24;
    localparam int COLUMNS_DEFAULT = 80;
    localparam int QUEUE_DEPTH     = 2;

    // command kinds as they arrive on the port
    localparam logic [KIND_W-1:0] KIND_PUT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ATTR_ON  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ATTR_OFF = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERASE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd5;

    // special character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // operations after classification
    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_PUT      = 4'd1,
        OP_NEWLINE  = 4'd2,
        OP_RETURN   = 4'd3,
        OP_MOVE     = 4'd4,
        OP_ATTR_ON  = 4'd5,
        OP_ATTR_OFF = 4'd6,
        OP_ERASE    = 4'd7,
        OP_READ     = 4'd8
    } op_t;

    // classified command held in the queue
    typedef struct packed {
        op_t               op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attr_bits;
    } cmd_t;

    // status from the back end to the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

@@ sv/tscw_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module tscw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tscw_front.sv @@
`timescale 1ns / 1ps
// command front end: classifies incoming commands and queues them
module tscw_front #(
    parameter int ROWS    = tscw_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = tscw_pkg::COLUMNS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [tscw_pkg::KIND_W-1:0]   kind,
    input  logic [tscw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tscw_pkg::ROW_W-1:0]    row,
    input  logic [tscw_pkg::COL_W-1:0]    column,
    input  logic [tscw_pkg::ATTR_W-1:0]   attr_bits,
    input  tscw_pkg::back_status_t        status,
    output logic                          q_valid,
    input  logic                          q_ready,
    output tscw_pkg::cmd_t                q_cmd
);

    localparam int DEPTH  = tscw_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [tscw_pkg::ROW_W-1:0] LAST_ROW = tscw_pkg::ROW_W'(ROWS - 1);
    localparam logic [tscw_pkg::COL_W-1:0] LAST_COL = tscw_pkg::COL_W'(COLUMNS - 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tscw_pkg::cmd_t   entry_reg [DEPTH];
    tscw_pkg::cmd_t   cls;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    // classify the command and clamp the coordinates
    always_comb
    begin
        cls.row       = (row > LAST_ROW) ? LAST_ROW : row;
        cls.col       = (column > LAST_COL) ? LAST_COL : column;
        cls.char_code = char_code;
        cls.attr_bits = attr_bits;
        case (kind)
            tscw_pkg::KIND_PUT:
            begin
                if (char_code == tscw_pkg::CH_NEWLINE)
                    cls.op = tscw_pkg::OP_NEWLINE;
                else if (char_code == tscw_pkg::CH_RETURN)
                    cls.op = tscw_pkg::OP_RETURN;
                else
                    cls.op = tscw_pkg::OP_PUT;
            end
            tscw_pkg::KIND_MOVE:     cls.op = tscw_pkg::OP_MOVE;
            tscw_pkg::KIND_ATTR_ON:  cls.op = tscw_pkg::OP_ATTR_ON;
            tscw_pkg::KIND_ATTR_OFF: cls.op = tscw_pkg::OP_ATTR_OFF;
            tscw_pkg::KIND_ERASE:    cls.op = tscw_pkg::OP_ERASE;
            tscw_pkg::KIND_READ:     cls.op = tscw_pkg::OP_READ;
            default:                 cls.op = tscw_pkg::OP_NOP;
        endcase
    end

    // queue handshakes; nothing is taken during the clearing pass
    assign cmd_ready = (count_reg != FULL_CNT) && !status.clearing;
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ sv/tscw_back.sv @@
`timescale 1ns / 1ps
// command back end: cursor, attribute, cell store, fill sequencer, response register
module tscw_back #(
    parameter int ROWS    = tscw_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = tscw_pkg::COLUMNS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  tscw_pkg::cmd_t                q_cmd,
    output tscw_pkg::back_status_t        status,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [tscw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tscw_pkg::COL_W-1:0]    cursor_col,
    output logic [tscw_pkg::CHAR_W-1:0]   cell_char,
    output logic [tscw_pkg::ATTR_W-1:0]   cell_attr
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DATA_W = tscw_pkg::CHAR_W + tscw_pkg::ATTR_W;
    localparam int RW     = tscw_pkg::ROW_W;
    localparam int CW     = tscw_pkg::COL_W;
    localparam int AW     = tscw_pkg::ATTR_W;
    localparam int HW     = tscw_pkg::CHAR_W;
    localparam int FW     = tscw_pkg::ADDR_FULL_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_FILL = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [AW-1:0]     cur_attr_reg, cur_attr_next;
    logic [RW-1:0]     sw_row_reg, sw_row_next;
    logic [CW-1:0]     sw_col_reg, sw_col_next;
    logic              sw_all_reg, sw_all_next;
    logic              sw_reply_reg, sw_reply_next;
    logic [AW-1:0]     fill_attr_reg, fill_attr_next;
    logic              out_valid_reg, out_valid_next;
    logic [RW-1:0]     out_row_reg, out_row_next;
    logic [CW-1:0]     out_col_reg, out_col_next;
    logic [HW-1:0]     out_char_reg, out_char_next;
    logic [AW-1:0]     out_attr_reg, out_attr_next;

    logic              slot_free;
    logic              pop;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              fill_last;

    // linear cell address from row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                    input logic [CW-1:0] c);
        logic [FW-1:0] full;
        full = FW'(r) * FW'(COLUMNS) + FW'(c);
        return full[ADDR_W-1:0];
    endfunction

    // cell store: character in the upper byte, attribute in the lower
    tscw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshakes and status
    assign slot_free       = !out_valid_reg || rsp_ready;
    assign q_ready         = (state_reg == ST_IDLE) && slot_free;
    assign pop             = q_valid && q_ready;
    assign status.clearing = (state_reg == ST_FILL) && !sw_reply_reg;
    assign fill_last       = (sw_col_reg == LAST_COL) && (!sw_all_reg || sw_row_reg == LAST_ROW);

    assign ram_re    = pop && (q_cmd.op == tscw_pkg::OP_READ);
    assign ram_raddr = cell_addr(q_cmd.row, q_cmd.col);

    // command execution and fill sequencing
    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_attr_next  = cur_attr_reg;
        sw_row_next    = sw_row_reg;
        sw_col_next    = sw_col_reg;
        sw_all_next    = sw_all_reg;
        sw_reply_next  = sw_reply_reg;
        fill_attr_next = fill_attr_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        ram_we         = 1'b0;
        ram_waddr      = cell_addr(cur_row_reg, cur_col_reg);
        ram_wdata      = {q_cmd.char_code, cur_attr_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    out_char_next = '0;
                    out_attr_next = '0;
                    case (q_cmd.op)
                        tscw_pkg::OP_PUT:
                        begin
                            ram_we = 1'b1;
                            if (cur_col_reg == LAST_COL)
                            begin
                                cur_col_next = '0;
                                cur_row_next = (cur_row_reg == LAST_ROW) ? '0
                                                                         : cur_row_reg + 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        tscw_pkg::OP_NEWLINE:
                        begin
                            sw_row_next    = cur_row_reg;
                            sw_col_next    = cur_col_reg;
                            sw_all_next    = 1'b0;
                            sw_reply_next  = 1'b1;
                            fill_attr_next = cur_attr_reg;
                            cur_col_next   = '0;
                            cur_row_next   = (cur_row_reg == LAST_ROW) ? '0
                                                                       : cur_row_reg + 1'b1;
                            state_next     = ST_FILL;
                        end
                        tscw_pkg::OP_RETURN:   cur_col_next = '0;
                        tscw_pkg::OP_MOVE:
                        begin
                            cur_row_next = q_cmd.row;
                            cur_col_next = q_cmd.col;
                        end
                        tscw_pkg::OP_ATTR_ON:  cur_attr_next = cur_attr_reg | q_cmd.attr_bits;
                        tscw_pkg::OP_ATTR_OFF: cur_attr_next = cur_attr_reg & ~q_cmd.attr_bits;
                        tscw_pkg::OP_ERASE:
                        begin
                            sw_row_next    = '0;
                            sw_col_next    = '0;
                            sw_all_next    = 1'b1;
                            sw_reply_next  = 1'b1;
                            fill_attr_next = '0;
                            cur_row_next   = '0;
                            cur_col_next   = '0;
                            cur_attr_next  = '0;
                            state_next     = ST_FILL;
                        end
                        tscw_pkg::OP_READ:     state_next = ST_READ;
                        default:               state_next = ST_IDLE;
                    endcase
                    // commands that finish in the idle state register their response directly
                    if (state_next == ST_IDLE)
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = cur_row_next;
                        out_col_next   = cur_col_next;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_row_next   = cur_row_reg;
                out_col_next   = cur_col_reg;
                out_char_next  = ram_rdata[DATA_W-1:AW];
                out_attr_next  = ram_rdata[AW-1:0];
                state_next     = ST_IDLE;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(sw_row_reg, sw_col_reg);
                ram_wdata = {tscw_pkg::CH_SPACE, fill_attr_reg};
                if (fill_last)
                begin
                    state_next = ST_IDLE;
                    if (sw_reply_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = cur_row_reg;
                        out_col_next   = cur_col_reg;
                        out_char_next  = '0;
                        out_attr_next  = '0;
                    end
                end
                else if (sw_col_reg == LAST_COL)
                begin
                    sw_col_next = '0;
                    sw_row_next = sw_row_reg + 1'b1;
                end
                else
                begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state; reset starts the clearing pass over the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_attr_reg  <= '0;
            sw_row_reg    <= '0;
            sw_col_reg    <= '0;
            sw_all_reg    <= 1'b1;
            sw_reply_reg  <= 1'b0;
            fill_attr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_attr_reg  <= cur_attr_next;
            sw_row_reg    <= sw_row_next;
            sw_col_reg    <= sw_col_next;
            sw_all_reg    <= sw_all_next;
            sw_reply_reg  <= sw_reply_next;
            fill_attr_reg <= fill_attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;

    // a read or a replying fill never starts with a response still pending
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("read in flight while a response is pending");

    a_fill_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && sw_reply_reg) |-> !out_valid_reg)
        else $error("fill in flight while a response is pending");

    // a popped read enters its data state in the next cycle
    a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_cmd.op == tscw_pkg::OP_READ) |=> (state_reg == ST_READ))
        else $error("read did not enter its data cycle");

    // cursor and sweep position stay on the screen
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= LAST_ROW) && (cur_col_reg <= LAST_COL)
        && (sw_row_reg <= LAST_ROW) && (sw_col_reg <= LAST_COL))
        else $error("cursor or sweep position off screen");

endmodule

@@ sv/text_screen_cell_writer_top.sv @@
`timescale 1ns / 1ps
// Responses: put, return, move and attribute commands answer from a response register
// once the back end takes them; reads answer after the registered cell store read;
// newline and erase answer after blanking the rest of the cursor row or the whole
// store, one cell per cycle. Throughput: one simple command per cycle while the back
// end is idle and its response slot is free; a two-entry queue keeps the front accepting during fills.
// Reset: cursor and attribute clear at once; a clearing pass then writes every cell
// to a space with attribute 0, with cmd_ready held low.
module text_screen_cell_writer_top #(
    parameter int ROWS    = tscw_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = tscw_pkg::COLUMNS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [tscw_pkg::KIND_W-1:0]   kind,
    input  logic [tscw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tscw_pkg::ROW_W-1:0]    row,
    input  logic [tscw_pkg::COL_W-1:0]    column,
    input  logic [tscw_pkg::ATTR_W-1:0]   attr_bits,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [tscw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tscw_pkg::COL_W-1:0]    cursor_col,
    output logic [tscw_pkg::CHAR_W-1:0]   cell_char,
    output logic [tscw_pkg::ATTR_W-1:0]   cell_attr
);

    logic                   q_valid;
    logic                   q_ready;
    tscw_pkg::cmd_t         q_cmd;
    tscw_pkg::back_status_t status;

    // classify and queue
    tscw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .kind      (kind),
        .char_code (char_code),
        .row       (row),
        .column    (column),
        .attr_bits (attr_bits),
        .status    (status),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd)
    );

    // execute and respond
    tscw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .status     (status),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr)
    );

endmodule
